@@ src/rau_pkg.sv @@
// Shared types and constants for the rational arithmetic unit.
`default_nettype none

package rau_pkg;

   localparam int NUM_WIDTH_DEF = 16;
   localparam int ACC_WIDTH_DEF = 8;
   localparam int OP_WIDTH      = 3;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD    = 3'd0,
      OP_SUB    = 3'd1,
      OP_MUL    = 3'd2,
      OP_DIV    = 3'd3,
      OP_NEG    = 3'd4,
      OP_ABS    = 3'd5,
      OP_REDUCE = 3'd6
   } op_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic gcd_step;
      logic div_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic reduce_go;
      logic gcd_eq;
      logic div_last;
   } stat_type;

endpackage

`default_nettype wire

@@ src/rational_arith_unit.sv @@
// Top level of the rational arithmetic unit.
//
// Requests arrive on the req_ stream: req_tuser carries the operation code and
// req_tdata the two fractions with their accuracy tags. Each request yields
// exactly one word on the rsp_ stream: numerator, denominator and accuracy tag.
// A word moves when tvalid and tready are both high at a rising clock edge.
//
// Add, sub, mul, div, neg, abs, the unknown code and a reduce with a zero
// numerator or denominator step through load on acceptance, multiply and
// finish, which registers the word and raises tvalid. Any other reduce adds
// a binary GCD loop (one shift or subtract a cycle) and bit-serial division
// between multiply and finish. One request is worked on at a time.
//
// The result sits in an output register; the next request is taken while it
// waits. If the receiver stalls, the finished item holds in the datapath
// until the output register is free, and no further request is accepted.
// Synchronous reset clears the controller and drops any pending result.
`default_nettype none

module rational_arith_unit #(
   parameter int NUM_WIDTH = rau_pkg::NUM_WIDTH_DEF,
   parameter int ACC_WIDTH = rau_pkg::ACC_WIDTH_DEF,
   localparam int REQ_DATA_W = ((4 * NUM_WIDTH + 2 * ACC_WIDTH + 7) / 8) * 8,
   localparam int RSP_DATA_W = ((4 * NUM_WIDTH + ACC_WIDTH + 2 + 7) / 8) * 8
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   // a_num, a_den, a_acc, b_num, b_den, b_acc, zero fill
   input  wire [REQ_DATA_W-1:0]           req_tdata,
   // req_type
   input  wire [rau_pkg::OP_WIDTH-1:0]    req_tuser,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   // res_num, res_den, res_acc, zero fill
   output logic [RSP_DATA_W-1:0]          rsp_tdata
);

   localparam int NW = NUM_WIDTH;
   localparam int AW = ACC_WIDTH;

   rau_pkg::cmd_type          cmd;
   rau_pkg::stat_type         stat;
   logic signed [2*NW:0]      res_num;
   logic signed [2*NW-1:0]    res_den;
   logic [AW:0]               res_acc;

   rau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   rau_dp #(
      .NUM_WIDTH (NUM_WIDTH),
      .ACC_WIDTH (ACC_WIDTH)
   ) u_dp (
      .clock    (clock),
      .cmd      (cmd),
      .stat     (stat),
      .req_type (req_tuser),
      .a_num    ($signed(req_tdata[NW-1:0])),
      .a_den    ($signed(req_tdata[2*NW-1:NW])),
      .a_acc    (req_tdata[2*NW+AW-1:2*NW]),
      .b_num    ($signed(req_tdata[3*NW+AW-1:2*NW+AW])),
      .b_den    ($signed(req_tdata[4*NW+AW-1:3*NW+AW])),
      .b_acc    (req_tdata[4*NW+2*AW-1:4*NW+AW]),
      .res_num  (res_num),
      .res_den  (res_den),
      .res_acc  (res_acc)
   );

   assign rsp_tdata = RSP_DATA_W'({res_acc, res_den, res_num});

endmodule

`default_nettype wire

@@ src/rau_dp.sv @@
// Datapath of the rational arithmetic unit: operand registers, multipliers, GCD and dividers.
`default_nettype none

module rau_dp #(
   parameter int NUM_WIDTH = rau_pkg::NUM_WIDTH_DEF,
   parameter int ACC_WIDTH = rau_pkg::ACC_WIDTH_DEF
) (
   input  wire                            clock,
   input  wire rau_pkg::cmd_type          cmd,
   output rau_pkg::stat_type              stat,
   input  wire [rau_pkg::OP_WIDTH-1:0]    req_type,
   input  wire signed [NUM_WIDTH-1:0]     a_num,
   input  wire signed [NUM_WIDTH-1:0]     a_den,
   input  wire [ACC_WIDTH-1:0]            a_acc,
   input  wire signed [NUM_WIDTH-1:0]     b_num,
   input  wire signed [NUM_WIDTH-1:0]     b_den,
   input  wire [ACC_WIDTH-1:0]            b_acc,
   output logic signed [2*NUM_WIDTH:0]    res_num,
   output logic signed [2*NUM_WIDTH-1:0]  res_den,
   output logic [ACC_WIDTH:0]             res_acc
);

   localparam int NW = NUM_WIDTH;
   localparam int PW = 2 * NUM_WIDTH;
   localparam int KW = $clog2(NUM_WIDTH);

   rau_pkg::op_type        op_ff;
   logic signed [NW-1:0]   an_ff, ad_ff, bn_ff, bd_ff;
   logic [ACC_WIDTH-1:0]   aa_ff, ba_ff;

   logic signed [PW-1:0]   p0_ff, p1_ff, p2_ff;
   logic signed [PW-1:0]   p0_in, p1_in, p2_in;

   logic [NW-1:0]          x_ff, y_ff, x_in, y_in;
   logic [KW-1:0]          k_ff, k_in;

   logic [NW-1:0]          g_ff;
   logic [NW-1:0]          qn_ff, qd_ff, qn_in, qd_in;
   logic [NW-1:0]          rn_ff, rd_ff, rn_in, rd_in;
   logic [KW-1:0]          cnt_ff;

   logic [NW-1:0]          an_mag, ad_mag;
   logic [NW:0]            tn, td;

   logic signed [PW:0]     res_num_in;
   logic signed [PW-1:0]   res_den_in;
   logic [ACC_WIDTH:0]     res_acc_in;
   logic [ACC_WIDTH:0]     acc_max, acc_sum;
   logic signed [PW:0]     qn_ext, qd_ext;

   assign an_mag = an_ff[NW-1] ? NW'(-an_ff) : an_ff;
   assign ad_mag = ad_ff[NW-1] ? NW'(-ad_ff) : ad_ff;

   assign stat.reduce_go = (op_ff == rau_pkg::OP_REDUCE) && (an_ff != '0) && (ad_ff != '0);
   assign stat.gcd_eq    = (x_ff == y_ff);
   assign stat.div_last  = (cnt_ff == '0);

   // products: mul pairs straight, div crosses, add/sub use all three
   always_comb begin
      p0_in = an_ff * ((op_ff == rau_pkg::OP_MUL) ? bn_ff : bd_ff);
      p1_in = bn_ff * ad_ff;
      p2_in = ad_ff * ((op_ff == rau_pkg::OP_DIV) ? bn_ff : bd_ff);
   end

   // one binary GCD step: strip common twos, strip lone twos, subtract odds
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      k_in = k_ff;
      if (!x_ff[0] && !y_ff[0]) begin
         x_in = x_ff >> 1;
         y_in = y_ff >> 1;
         k_in = k_ff + KW'(1);
      end else if (!x_ff[0]) begin
         x_in = x_ff >> 1;
      end else if (!y_ff[0]) begin
         y_in = y_ff >> 1;
      end else if (x_ff > y_ff) begin
         x_in = x_ff - y_ff;
      end else begin
         y_in = y_ff - x_ff;
      end
   end

   // restoring division, one quotient bit per cycle for both magnitudes
   always_comb begin
      tn = {rn_ff, qn_ff[NW-1]};
      td = {rd_ff, qd_ff[NW-1]};
      if (tn >= {1'b0, g_ff}) begin
         rn_in = NW'(tn - {1'b0, g_ff});
         qn_in = {qn_ff[NW-2:0], 1'b1};
      end else begin
         rn_in = tn[NW-1:0];
         qn_in = {qn_ff[NW-2:0], 1'b0};
      end
      if (td >= {1'b0, g_ff}) begin
         rd_in = NW'(td - {1'b0, g_ff});
         qd_in = {qd_ff[NW-2:0], 1'b1};
      end else begin
         rd_in = td[NW-1:0];
         qd_in = {qd_ff[NW-2:0], 1'b0};
      end
   end

   always_comb begin
      acc_max = (aa_ff > ba_ff) ? {1'b0, aa_ff} : {1'b0, ba_ff};
      acc_sum = {1'b0, aa_ff} + {1'b0, ba_ff};
      qn_ext  = $signed({{(PW+1-NW){1'b0}}, qn_ff});
      qd_ext  = $signed({{(PW+1-NW){1'b0}}, qd_ff});
      res_num_in = '0;
      res_den_in = '0;
      res_acc_in = '0;
      case (op_ff)
         rau_pkg::OP_ADD: begin
            res_num_in = {p0_ff[PW-1], p0_ff} + {p1_ff[PW-1], p1_ff};
            res_den_in = p2_ff;
            res_acc_in = acc_max;
         end
         rau_pkg::OP_SUB: begin
            res_num_in = {p0_ff[PW-1], p0_ff} - {p1_ff[PW-1], p1_ff};
            res_den_in = p2_ff;
            res_acc_in = acc_max;
         end
         rau_pkg::OP_MUL, rau_pkg::OP_DIV: begin
            res_num_in = {p0_ff[PW-1], p0_ff};
            res_den_in = p2_ff;
            res_acc_in = acc_sum;
         end
         rau_pkg::OP_NEG: begin
            res_num_in = -(PW+1)'(an_ff);
            res_den_in = PW'(ad_ff);
            res_acc_in = {1'b0, aa_ff};
         end
         rau_pkg::OP_ABS: begin
            res_num_in = $signed({{(PW+1-NW){1'b0}}, an_mag});
            res_den_in = $signed({{(PW-NW){1'b0}}, ad_mag});
            res_acc_in = {1'b0, aa_ff};
         end
         rau_pkg::OP_REDUCE: begin
            res_acc_in = {1'b0, aa_ff};
            if (stat.reduce_go) begin
               res_num_in = an_ff[NW-1] ? -qn_ext : qn_ext;
               res_den_in = ad_ff[NW-1] ? PW'(-qd_ext) : PW'(qd_ext);
            end else begin
               res_num_in = (PW+1)'(an_ff);
               res_den_in = PW'(ad_ff);
            end
         end
         default: begin
            res_num_in = '0;
            res_den_in = '0;
            res_acc_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= rau_pkg::op_type'(req_type);
         an_ff <= a_num;
         ad_ff <= a_den;
         aa_ff <= a_acc;
         bn_ff <= b_num;
         bd_ff <= b_den;
         ba_ff <= b_acc;
      end
      if (cmd.mul) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         x_ff  <= an_mag;
         y_ff  <= ad_mag;
         k_ff  <= '0;
      end
      if (cmd.gcd_step) begin
         if (stat.gcd_eq) begin
            // GCD settled: restore common twos and prime the dividers
            g_ff   <= x_ff << k_ff;
            qn_ff  <= an_mag;
            qd_ff  <= ad_mag;
            rn_ff  <= '0;
            rd_ff  <= '0;
            cnt_ff <= KW'(NW - 1);
         end else begin
            x_ff <= x_in;
            y_ff <= y_in;
            k_ff <= k_in;
         end
      end
      if (cmd.div_step) begin
         qn_ff  <= qn_in;
         qd_ff  <= qd_in;
         rn_ff  <= rn_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_ff - KW'(1);
      end
      if (cmd.finish) begin
         res_num <= res_num_in;
         res_den <= res_den_in;
         res_acc <= res_acc_in;
      end
   end

endmodule

`default_nettype wire

@@ src/rau_ctrl.sv @@
// Control state machine of the rational arithmetic unit.
`default_nettype none

module rau_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output rau_pkg::cmd_type        cmd,
   input  wire rau_pkg::stat_type  stat
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_MUL  = 5'b00010,
      S_GCD  = 5'b00100,
      S_DIV  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = stat.reduce_go ? S_GCD : S_DONE;
         end
         S_GCD: begin
            cmd.gcd_step = 1'b1;
            if (stat.gcd_eq) begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output word is free or leaving this cycle
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ bench/rational_arith_unit_test.sv @@
// Self-checking testbench for the rational arithmetic unit.
`timescale 1ns / 100ps

module rational_arith_unit_test;

   localparam int NW = rau_pkg::NUM_WIDTH_DEF;
   localparam int AW = rau_pkg::ACC_WIDTH_DEF;
   localparam int OW = rau_pkg::OP_WIDTH;
   localparam int REQ_W = ((4 * NW + 2 * AW + 7) / 8) * 8;
   localparam int RSP_W = ((4 * NW + AW + 2 + 7) / 8) * 8;
   localparam int RSP_FILL = RSP_W - (4 * NW + AW + 2);
   localparam logic [OW-1:0] OP_UNKNOWN = 3'd7;
   localparam int DRAIN_CYCLES = 200;

   // packed so that a_num sits in the lowest bits of the word
   typedef struct packed {
      logic [AW-1:0]        b_acc;
      logic signed [NW-1:0] b_den;
      logic signed [NW-1:0] b_num;
      logic [AW-1:0]        a_acc;
      logic signed [NW-1:0] a_den;
      logic signed [NW-1:0] a_num;
   } operands_type;

   typedef struct packed {
      logic [RSP_FILL-1:0]    fill;
      logic [AW:0]            acc;
      logic signed [2*NW-1:0] den;
      logic signed [2*NW:0]   num;
   } fraction_type;

   class fraction_scoreboard_type;
      fraction_type pending_fractions[$];
      int           errors = 0;

      function automatic fraction_type compute_fraction(logic [OW-1:0] op,
                                                        operands_type r);
         longint       an, ad, bn, bd, rn, rd, x, y, t;
         int           aa, ba, ra;
         fraction_type f;
         an = longint'(r.a_num);
         ad = longint'(r.a_den);
         bn = longint'(r.b_num);
         bd = longint'(r.b_den);
         aa = int'(r.a_acc);
         ba = int'(r.b_acc);
         rn = 0;
         rd = 0;
         ra = 0;
         case (op)
            rau_pkg::OP_ADD: begin
               rn = an * bd + bn * ad;
               rd = ad * bd;
               ra = (aa > ba) ? aa : ba;
            end
            rau_pkg::OP_SUB: begin
               rn = an * bd - bn * ad;
               rd = ad * bd;
               ra = (aa > ba) ? aa : ba;
            end
            rau_pkg::OP_MUL: begin
               rn = an * bn;
               rd = ad * bd;
               ra = aa + ba;
            end
            rau_pkg::OP_DIV: begin
               rn = an * bd;
               rd = ad * bn;
               ra = aa + ba;
            end
            rau_pkg::OP_NEG: begin
               rn = -an;
               rd = ad;
               ra = aa;
            end
            rau_pkg::OP_ABS: begin
               rn = (an < 0) ? -an : an;
               rd = (ad < 0) ? -ad : ad;
               ra = aa;
            end
            rau_pkg::OP_REDUCE: begin
               rn = an;
               rd = ad;
               ra = aa;
               if (an != 0 && ad != 0) begin
                  x = (an < 0) ? -an : an;
                  y = (ad < 0) ? -ad : ad;
                  while (y != 0) begin
                     t = x % y;
                     x = y;
                     y = t;
                  end
                  // exact division, truncation keeps each sign
                  rn = an / x;
                  rd = ad / x;
               end
            end
            default: ;
         endcase
         f.fill = '0;
         f.num  = rn[2*NW:0];
         f.den  = rd[2*NW-1:0];
         f.acc  = ra[AW:0];
         return f;
      endfunction

      function automatic void note_request(logic [OW-1:0] op, logic [REQ_W-1:0] word);
         operands_type r;
         r = operands_type'(word[4*NW+2*AW-1:0]);
         pending_fractions.push_back(compute_fraction(op, r));
      endfunction

      function automatic void check_word(logic [RSP_W-1:0] word);
         fraction_type got, want;
         got = fraction_type'(word);
         if (pending_fractions.size() == 0) begin
            $display("%0t: unexpected result word %h", $time, word);
            errors++;
            return;
         end
         want = pending_fractions.pop_front();
         if (got.num !== want.num) begin
            $display("%0t: res_num expected %0d got %0d", $time, want.num, got.num);
            errors++;
         end
         if (got.den !== want.den) begin
            $display("%0t: res_den expected %0d got %0d", $time, want.den, got.den);
            errors++;
         end
         if (got.acc !== want.acc) begin
            $display("%0t: res_acc expected %0d got %0d", $time, want.acc, got.acc);
            errors++;
         end
      endfunction

      function automatic int pending();
         return pending_fractions.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata = '0;
   logic [OW-1:0]       req_tuser = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;

   fraction_scoreboard_type book = new();

   rational_arith_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // sample both handshakes with the values from before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            book.note_request(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            book.check_word(rsp_tdata);
      end
   end

   task automatic send_fraction(logic [OW-1:0] op,
                                logic signed [NW-1:0] an, logic signed [NW-1:0] ad,
                                logic [AW-1:0] aa,
                                logic signed [NW-1:0] bn, logic signed [NW-1:0] bd,
                                logic [AW-1:0] ba);
      operands_type r;
      r = '{b_acc: ba, b_den: bd, b_num: bn, a_acc: aa, a_den: ad, a_num: an};
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'(r);
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off the sender until every result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (book.pending() != 0) @(posedge clock);
   endtask

   function automatic logic signed [NW-1:0] pick_value();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return NW'($urandom);
         5, 6, 7:       return NW'(int'($urandom_range(0, 64)) - 32);
         8: begin
            case ($urandom_range(0, 4))
               0:       return 16'sh8000;
               1:       return 16'sh7fff;
               2:       return 16'sh0000;
               3:       return 16'sh0001;
               default: return 16'shffff;
            endcase
         end
         default: begin
            // signed power of two, deep binary GCD shifts
            if ($urandom_range(0, 1) == 1)
               return -(NW'(1) << $urandom_range(0, NW - 2));
            return NW'(1) << $urandom_range(0, NW - 2);
         end
      endcase
   endfunction

   function automatic logic [AW-1:0] pick_acc();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return AW'($urandom);
      endcase
   endfunction

   task automatic send_random();
      logic [OW-1:0]        op;
      logic signed [NW-1:0] an, ad;
      int                   k;
      op = ($urandom_range(0, 19) == 0) ? OP_UNKNOWN : OW'($urandom_range(0, 6));
      an = pick_value();
      ad = pick_value();
      if (op == rau_pkg::OP_REDUCE && $urandom_range(0, 1) == 1) begin
         // share a factor so the reduction does real work
         k  = $urandom_range(1, 255);
         an = NW'(k * $urandom_range(0, 127));
         ad = NW'(k * $urandom_range(1, 127));
         if ($urandom_range(0, 1) == 1) an = -an;
         if ($urandom_range(0, 1) == 1) ad = -ad;
      end
      send_fraction(op, an, ad, pick_acc(), pick_value(), pick_value(), pick_acc());
   endtask

   task automatic run_random(int count);
      for (int i = 0; i < count; i++) begin
         send_random();
         if (i == count / 2)
            drain_results();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      req_idle_pct = 17;
      rsp_idle_pct = 86;
      send_fraction(rau_pkg::OP_ADD, 16'sh8000, 16'sh8000, 8'd0,
                    16'sh8000, 16'sh8000, 8'd255);
      send_fraction(rau_pkg::OP_ADD, 16'sh7fff, 16'sh7fff, 8'd255,
                    16'sh7fff, 16'sh7fff, 8'd0);
      send_fraction(rau_pkg::OP_SUB, 16'sh8000, 16'sh7fff, 8'd3,
                    16'sh7fff, 16'sh8000, 8'd9);
      send_fraction(rau_pkg::OP_SUB, 16'sh8000, 16'sh8000, 8'd200,
                    16'sh7fff, 16'sh7fff, 8'd100);
      send_fraction(rau_pkg::OP_MUL, 16'sh8000, 16'sh8000, 8'd255,
                    16'sh8000, 16'sh8000, 8'd255);
      send_fraction(rau_pkg::OP_MUL, 16'sh7fff, 16'sh0000, 8'd1,
                    16'sh8000, 16'sh0005, 8'd2);
      send_fraction(rau_pkg::OP_DIV, 16'sh8000, 16'sh7fff, 8'd255,
                    16'sh0000, 16'sh8000, 8'd255);
      send_fraction(rau_pkg::OP_DIV, 16'sh0003, 16'sh0004, 8'd0,
                    16'shfffb, 16'sh0007, 8'd0);
      send_fraction(rau_pkg::OP_NEG, 16'sh8000, 16'sh8000, 8'd255,
                    16'sh1234, 16'sh5678, 8'd77);
      send_fraction(rau_pkg::OP_NEG, 16'sh7fff, 16'sh0000, 8'd0,
                    16'sh8000, 16'sh8000, 8'd255);
      send_fraction(rau_pkg::OP_ABS, 16'sh8000, 16'sh8000, 8'd128,
                    16'sh7fff, 16'sh7fff, 8'd1);
      send_fraction(rau_pkg::OP_ABS, 16'sh7fff, 16'shffff, 8'd1,
                    16'sh0000, 16'sh0000, 8'd0);
      send_fraction(rau_pkg::OP_REDUCE, 16'sh0000, 16'sh0006, 8'd5,
                    16'sh0003, 16'sh0003, 8'd6);
      send_fraction(rau_pkg::OP_REDUCE, 16'shfffa, 16'sh0000, 8'd6,
                    16'sh0001, 16'sh0001, 8'd7);
      send_fraction(rau_pkg::OP_REDUCE, 16'sh8000, 16'sh8000, 8'd255,
                    16'sh0000, 16'sh0000, 8'd0);
      send_fraction(rau_pkg::OP_REDUCE, 16'sh000c, 16'shffee, 8'd12,
                    16'sh0000, 16'sh0000, 8'd0);
      send_fraction(rau_pkg::OP_REDUCE, 16'shffee, 16'shfff4, 8'd0,
                    16'sh0000, 16'sh0000, 8'd0);
      send_fraction(rau_pkg::OP_REDUCE, 16'sh7fff, 16'sh7ffe, 8'd1,
                    16'sh0000, 16'sh0000, 8'd0);
      send_fraction(rau_pkg::OP_REDUCE, 16'sh8000, 16'sh0001, 8'd2,
                    16'sh0000, 16'sh0000, 8'd0);
      send_fraction(rau_pkg::OP_REDUCE, 16'sh4000, 16'shc000, 8'd3,
                    16'sh0000, 16'sh0000, 8'd0);
      send_fraction(OP_UNKNOWN, 16'sh7fff, 16'sh7fff, 8'd255, 16'sh7fff, 16'sh7fff, 8'd255);
      send_fraction(OP_UNKNOWN, 16'sh8000, 16'sh8000, 8'd0, 16'sh8000, 16'sh8000, 8'd0);
      drain_results();

      run_random(330);
      req_idle_pct = 86;
      rsp_idle_pct = 17;
      run_random(330);
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(340);

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (book.errors == 0 && book.pending() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
